### rtl/assert_macros.svh
// Assertion macros used by the serial command packet parser RTL.
// Standalone header; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk, idle while rst is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks prop at every rising edge of clk, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/scpp_pkg.sv
// Package for the serial command packet parser: command codes and
// payload positions. No dependencies.
package scpp_pkg;

  // Command bytes recognized by the framer (ASCII).
  localparam logic [7:0] CMD_NONE  = 8'h00;
  localparam logic [7:0] CMD_HALT  = 8'h48;  // 'H'
  localparam logic [7:0] CMD_INFO  = 8'h49;  // 'I'
  localparam logic [7:0] CMD_POINT = 8'h50;  // 'P'
  localparam logic [7:0] CMD_SIZE  = 8'h53;  // 'S'

  // Payload positions of a point packet, counted from one.
  localparam logic [7:0] POS_DUR_HI   = 8'd1;
  localparam logic [7:0] POS_DUR_LO   = 8'd2;
  localparam logic [7:0] POS_TIME_HI  = 8'd3;
  localparam logic [7:0] POS_TIME_LO  = 8'd4;
  localparam logic [7:0] POS_COORD0   = 8'd5;
  localparam int unsigned TIMING_BYTES = 4;

endpackage

### rtl/scpp_if.sv
// Handshake channels of the serial command packet parser: the received
// byte channel and the parsed result channel. Depends on nothing.
interface scpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scpp_res_if;
  logic        valid;
  logic        ready;
  logic        done_res;
  logic [7:0]  command;
  logic [7:0]  point_dim;
  logic [15:0] duration;
  logic [15:0] time_to_target;
  logic        coord_valid;
  logic [2:0]  coord_index;
  logic [7:0]  coord_value;

  modport source (output valid, output done_res, output command, output point_dim,
                  output duration, output time_to_target, output coord_valid,
                  output coord_index, output coord_value, input ready);
  modport sink   (input valid, input done_res, input command, input point_dim,
                  input duration, input time_to_target, input coord_valid,
                  input coord_index, input coord_value, output ready);
endinterface

### rtl/serial_command_packet_parser.sv
// Serial command packet parser top level: frames received bytes into
// command packets. Depends on scpp_pkg, scpp_if.sv and assert_macros.svh.
//
//   channel   direction  payload                                   handshake
//   rx        in         rx_byte                                   valid/ready
//   res       out        done_res, command, point_dim, duration,  valid/ready
//                        time_to_target, coord_valid/index/value
//   cfg       in         cfg_wdata (store_points)                  cfg_we
//
// One word is taken per cycle while the output is not stalled; its result
// is registered at the edge that accepts it. The framing state and the result register update
// in the same edge, so throughput is one word per clock.
// The input stalls only when the output register holds a result that the
// sink does not take in that cycle. Synchronous active-high reset clears the
// framing state, the store_points register and the output valid.

`include "assert_macros.svh"

module serial_command_packet_parser
  import scpp_pkg::*;
#(
  parameter int unsigned POINT_DIM = 6
) (
  input  logic         clk,
  input  logic         rst,
  scpp_byte_if.sink    rx,
  scpp_res_if.source   res,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  // Payload bytes of a complete point packet: timing fields plus coordinates.
  localparam logic [7:0] PKT_LEN = 8'(POINT_DIM + TIMING_BYTES);

  // Configuration register.
  logic store_points;

  // Framing state.
  logic [7:0]  open_command, open_command_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] duration_acc, duration_acc_next;
  logic [15:0] time_acc, time_acc_next;
  logic [7:0]  held_dim, held_dim_next;

  // Result fields computed for the word being accepted.
  logic        done_next;
  logic [15:0] dur_out_next, ttt_out_next;
  logic        cvalid_next;
  logic [2:0]  cindex_next;
  logic [7:0]  cvalue_next;

  logic       take;
  logic       is_si, is_p, closed;
  logic [7:0] pos;

  // The output register frees up when it is empty or being drained.
  assign rx.ready = !res.valid || res.ready;
  assign take     = rx.valid && rx.ready;

  assign is_si = (open_command == CMD_SIZE) || (open_command == CMD_INFO);
  assign is_p  = (open_command == CMD_POINT);

  // A packet is closed when nothing useful is open (no command, a halt or an
  // unknown code) or when a size/info or point packet has all its payload.
  assign closed = !(is_si || is_p)
               || (is_si && (payload_count == 8'd1))
               || (is_p && (payload_count == PKT_LEN));

  // Position of the incoming byte within a point payload.
  assign pos = payload_count + 8'd1;

  always_comb begin
    open_command_next  = open_command;
    payload_count_next = payload_count;
    duration_acc_next  = duration_acc;
    time_acc_next      = time_acc;
    held_dim_next      = held_dim;
    done_next          = 1'b0;
    dur_out_next       = '0;
    ttt_out_next       = '0;
    cvalid_next        = 1'b0;
    cindex_next        = '0;
    cvalue_next        = '0;

    if (closed) begin
      // The byte opens a new packet; a halt completes right away.
      payload_count_next = '0;
      open_command_next  = rx.rx_byte;
      done_next          = (rx.rx_byte == CMD_HALT);
    end else if (is_si) begin
      held_dim_next      = rx.rx_byte;
      payload_count_next = 8'd1;
      done_next          = 1'b1;
    end else begin
      payload_count_next = pos;
      // Point payload is captured only while a destination is armed; the
      // accumulators otherwise keep whatever they held.
      if (store_points) begin
        case (pos)
          POS_DUR_HI:  duration_acc_next = {rx.rx_byte, 8'h00};
          POS_DUR_LO:  duration_acc_next = duration_acc + {8'h00, rx.rx_byte};
          POS_TIME_HI: time_acc_next     = {rx.rx_byte, 8'h00};
          POS_TIME_LO: time_acc_next     = time_acc + {8'h00, rx.rx_byte};
          default: begin
            cvalid_next = 1'b1;
            cindex_next = 3'(pos - POS_COORD0);
            cvalue_next = rx.rx_byte;
          end
        endcase
      end
      if (pos == PKT_LEN) begin
        done_next = 1'b1;
        if (store_points) begin
          dur_out_next = duration_acc_next;
          ttt_out_next = time_acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_points <= 1'b0;
    end else if (cfg_we) begin
      store_points <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_command  <= CMD_NONE;
      payload_count <= '0;
      duration_acc  <= '0;
      time_acc      <= '0;
      held_dim      <= '0;
    end else if (take) begin
      open_command  <= open_command_next;
      payload_count <= payload_count_next;
      duration_acc  <= duration_acc_next;
      time_acc      <= time_acc_next;
      held_dim      <= held_dim_next;
    end
  end

  // Output valid: set by an accepted word, cleared when the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Output payload register, loaded with each accepted word's result.
  always_ff @(posedge clk) begin
    if (take) begin
      res.done_res       <= done_next;
      res.command        <= open_command_next;
      res.point_dim      <= held_dim_next;
      res.duration       <= dur_out_next;
      res.time_to_target <= ttt_out_next;
      res.coord_valid    <= cvalid_next;
      res.coord_index    <= cindex_next;
      res.coord_value    <= cvalue_next;
    end
  end

  // A coordinate is only ever reported inside a point packet.
  `ASSERT_CLK_RST(a_coord_in_point, clk, rst, (res.valid && res.coord_valid) |-> (res.command == CMD_POINT), "coordinate reported outside a point packet")

  // Timing fields appear only on a completing point packet.
  `ASSERT_CLK_RST(a_timing_at_done, clk, rst, (res.valid && ((res.duration != 16'h0000) || (res.time_to_target != 16'h0000))) |-> (res.done_res && (res.command == CMD_POINT)), "timing reported off a completed point packet")

  // The payload counter never runs past the length of a point packet.
  `ASSERT_CLK_RST(a_count_bound, clk, rst, payload_count <= PKT_LEN, "payload count overran packet length")

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the serial command packet parser top level.
// Depends on scpp_pkg, the scpp_byte_if and scpp_res_if interfaces, and the RTL.
module testbench;
  import scpp_pkg::*;

  localparam int unsigned POINT_DIM = 6;
  // Cycles with no word accepted on either channel before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // One parsed result word, laid out like the result channel payload.
  typedef struct packed {
    logic        done_res;
    logic [7:0]  command;
    logic [7:0]  point_dim;
    logic [15:0] duration;
    logic [15:0] time_to_target;
    logic        coord_valid;
    logic [2:0]  coord_index;
    logic [7:0]  coord_value;
  } parse_t;

  // Tracks the framing state of the parser, predicts the result of every
  // accepted byte and compares the results that come out, in order.
  class parse_checker;
    logic        store_on;
    logic [7:0]  open_cmd;
    logic [7:0]  payload_cnt;
    logic [15:0] dur_acc;
    logic [15:0] ttt_acc;
    logic [7:0]  dim_held;
    parse_t      expected_parses[$];
    int unsigned failures;

    function new();
      store_on    = 1'b0;
      open_cmd    = CMD_NONE;
      payload_cnt = '0;
      dur_acc     = '0;
      ttt_acc     = '0;
      dim_held    = '0;
      failures    = 0;
    endfunction

    function int unsigned pending();
      return expected_parses.size();
    endfunction

    // The open packet accepts no more payload: nothing open, a halt, a full
    // size/info or point packet, or an unknown command byte.
    function bit packet_closed();
      bit dim_cmd;
      dim_cmd = (open_cmd == CMD_SIZE) || (open_cmd == CMD_INFO);
      if (open_cmd == CMD_NONE || open_cmd == CMD_HALT) return 1'b1;
      if (dim_cmd && payload_cnt == 8'd1) return 1'b1;
      if (open_cmd == CMD_POINT)
        return payload_cnt == POINT_DIM + TIMING_BYTES;
      return !dim_cmd;
    endfunction

    function void note_word(logic [7:0] b);
      parse_t     e;
      logic [7:0] pos;
      logic [7:0] idx;
      e = '0;
      if (packet_closed()) begin
        payload_cnt = '0;
        open_cmd    = b;
        e.done_res  = (b == CMD_HALT);
      end else if (open_cmd == CMD_SIZE || open_cmd == CMD_INFO) begin
        dim_held    = b;
        payload_cnt = 8'd1;
        e.done_res  = 1'b1;
      end else begin
        // Point packet: timing bytes first, then the coordinates.
        pos         = payload_cnt + 8'd1;
        payload_cnt = pos;
        if (store_on) begin
          case (pos)
            POS_DUR_HI:  dur_acc = {b, 8'h00};
            POS_DUR_LO:  dur_acc = dur_acc + {8'h00, b};
            POS_TIME_HI: ttt_acc = {b, 8'h00};
            POS_TIME_LO: ttt_acc = ttt_acc + {8'h00, b};
            default: begin
              idx           = pos - POS_COORD0;
              e.coord_valid = 1'b1;
              e.coord_index = idx[2:0];
              e.coord_value = b;
            end
          endcase
        end
        if (pos == POINT_DIM + TIMING_BYTES) begin
          e.done_res = 1'b1;
          if (store_on) begin
            e.duration       = dur_acc;
            e.time_to_target = ttt_acc;
          end
        end
      end
      e.command   = open_cmd;
      e.point_dim = dim_held;
      expected_parses.push_back(e);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(parse_t got);
      parse_t e;
      if (expected_parses.size() == 0) begin
        $error("result word arrived with no byte waiting for it");
        failures++;
        return;
      end
      e = expected_parses.pop_front();
      compare("done_res", e.done_res, got.done_res);
      compare("command", e.command, got.command);
      compare("point_dim", e.point_dim, got.point_dim);
      compare("duration", e.duration, got.duration);
      compare("time_to_target", e.time_to_target, got.time_to_target);
      compare("coord_valid", e.coord_valid, got.coord_valid);
      compare("coord_index", e.coord_index, got.coord_index);
      compare("coord_value", e.coord_value, got.coord_value);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  scpp_byte_if rx_ch();
  scpp_res_if  res_ch();

  serial_command_packet_parser #(.POINT_DIM(POINT_DIM)) dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  parse_checker sb = new();

  // Percent chance per cycle that the byte source holds back a word, and
  // that the result sink refuses one. Both change from phase to phase.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  // Result sink: every accepted result word is checked against the oldest
  // prediction, then ready is redrawn for the next cycle.
  always @(posedge clk) begin
    parse_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.done_res       = res_ch.done_res;
      got.command        = res_ch.command;
      got.point_dim      = res_ch.point_dim;
      got.duration       = res_ch.duration;
      got.time_to_target = res_ch.time_to_target;
      got.coord_valid    = res_ch.coord_valid;
      got.coord_index    = res_ch.coord_index;
      got.coord_value    = res_ch.coord_value;
      sb.check_result(got);
    end
    res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // The watchdog restarts whenever a word moves on either channel. A hang
  // anywhere in the block shows up as a long run of silent cycles.
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one byte, possibly after some idle cycles, and returns at the
  // edge where it is accepted. Valid is left high so back-to-back words do
  // not drop it; each call makes at most one assignment to valid per edge.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    sb.note_word(b);
  endtask

  // The register is only written with the block drained: every predicted
  // result has come out, then the task waits out the output register.
  task automatic write_store(input logic v);
    rx_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    sb.store_on  = v;
  endtask

  // Random byte biased toward the all-zeros and all-ones extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Builds one packet: mostly well-formed commands with random payload,
  // some unknown command bytes, truncated point packets and plain noise.
  task automatic make_packet(ref logic [7:0] pkt[$]);
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick < 15) begin
      pkt.push_back(CMD_HALT);
    end else if (pick < 30) begin
      pkt.push_back(CMD_SIZE);
      pkt.push_back(rand_byte());
    end else if (pick < 45) begin
      pkt.push_back(CMD_INFO);
      pkt.push_back(rand_byte());
    end else if (pick < 85) begin
      pkt.push_back(CMD_POINT);
      for (int i = 0; i < POINT_DIM + TIMING_BYTES; i++) pkt.push_back(rand_byte());
      // A broken point packet: whatever follows is swallowed as payload.
      if (pick >= 80) begin
        cut = $urandom_range(POINT_DIM + TIMING_BYTES, 1);
        while (pkt.size() > cut) void'(pkt.pop_back());
      end
    end else if (pick < 93) begin
      pkt.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(3, 1)) pkt.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [7:0]  pkt[$];
    int unsigned budget;
    int unsigned sent;

    // Directed words: a full point packet with extreme timing and coordinate
    // bytes, each short command, a zero command byte, and unknown command
    // bytes followed by a halt and by a size command.
    directed = '{CMD_POINT, 8'hFF, 8'hFF, 8'h00, 8'h01,
                 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                 CMD_HALT, CMD_SIZE, 8'hFF, CMD_INFO, 8'h00,
                 CMD_NONE, 8'hFF, CMD_HALT, 8'h5A, CMD_SIZE, 8'h7E};

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_store(1'b1);
    foreach (directed[i]) send_word(directed[i]);

    // Random phases. Each one picks an idling pattern and a store setting;
    // its byte budget ends at an arbitrary point, so a packet is often left
    // half framed when the store setting flips, and timing or coordinate
    // bytes then arrive under the new store setting.
    for (int ph = 0; ph < 8; ph++) begin
      write_store(logic'((ph + ph / 4) % 2));
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
        default: begin src_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      budget = $urandom_range(100, 70);
      sent   = 0;
      pkt.delete();
      while (sent < budget) begin
        if (pkt.size() == 0) make_packet(pkt);
        send_word(pkt.pop_front());
        sent++;
      end
    end
    rx_ch.valid <= 1'b0;

    // Drain: every byte has one result; then keep the clock running to catch
    // any stray result word.
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
